### src/shortest_path_dijkstra_defines.svh
// Assertion helpers used by the checker file.
`ifndef SHORTEST_PATH_DIJKSTRA_DEFINES_SVH
`define SHORTEST_PATH_DIJKSTRA_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define SP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication check, suspended while reset is asserted.
`define SP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sp_pkg.sv
package sp_pkg;

  localparam int VERT_W  = 7;
  localparam int OP_W    = 2;
  localparam int WIN_W   = 20;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

### src/sp_ram.sv
module sp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/shortest_path_dijkstra.sv
// Shortest path search, Dijkstra from vertex 1 to vertex node_count.
// Input channel (in_valid / in_stall): op 0 loads one undirected edge, and loads
// stream at one per cycle while no search runs; op 2 clears the graph.
// Op 1 runs the search; in_stall stays high until the last path transaction
// has been loaded into the output slot.
// Result channel (out_valid / out_stall): one transaction per path vertex from
// 1 to the target, last set on the final one, or a single transaction with
// unreachable set. A registered output slot holds a stalled result; the walk
// waits on it and resumes when it drains.
// A run fills the distance table, then for each settled vertex scans all vertices for
// the nearest unsettled one, marks it and relaxes the stored edges touching it; an
// empty scan ends it, and the path is walked back from the target and sent from vertex 1.
// Node state runs through one node memory port (read and write per cycle), edges
// through one edge memory read port and the path through a path memory, one access per step.
// cfg_we writes node_count; write it only while idle, the block does not enforce this. Reset (rst_n low, synchronous)
// empties the graph, clears the overflow flag and sets node_count to 64;
// memories are not cleared, every entry is written before it is read.
module shortest_path_dijkstra #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sp_pkg::VERT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sp_pkg::OP_W-1:0]     in_op,
  input  logic [sp_pkg::VERT_W-1:0]   in_edge_from,
  input  logic [sp_pkg::VERT_W-1:0]   in_edge_to,
  input  logic [sp_pkg::WIN_W-1:0]    in_edge_weight,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sp_pkg::VERT_W-1:0]   out_path_vertex,
  output logic                        out_last,
  output logic                        out_unreachable,
  output logic                        out_edges_dropped
);

  localparam int VW   = sp_pkg::VERT_W;
  localparam int AW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int DW   = WEIGHT_BITS + AW;
  localparam int NE_W = 2 + VW + DW;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int EW   = 2 * VW + WEIGHT_BITS;
  localparam int P_LO = DW;
  localparam int VIS  = DW + VW;
  localparam int RCH  = DW + VW + 1;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_INIT    = 14'b00000000000010,
    ST_SCAN_RD = 14'b00000000000100,
    ST_SCAN_EV = 14'b00000000001000,
    ST_MARK    = 14'b00000000010000,
    ST_E_RD    = 14'b00000000100000,
    ST_E_EV    = 14'b00000001000000,
    ST_N_EV    = 14'b00000010000000,
    ST_P_CHK   = 14'b00000100000000,
    ST_P_CHKEV = 14'b00001000000000,
    ST_P_PUSH  = 14'b00010000000000,
    ST_P_EV    = 14'b00100000000000,
    ST_O_RD    = 14'b01000000000000,
    ST_O_EV    = 14'b10000000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VW-1:0]          node_count_r;
  logic [ECW-1:0]         edge_count_r, edge_count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [AW-1:0]          best_idx_r, best_idx_nxt;
  logic [DW-1:0]          best_dist_r, best_dist_nxt;
  logic [VW-1:0]          best_par_r, best_par_nxt;
  logic [ECW-1:0]         k_r, k_nxt;
  logic [VW-1:0]          tgt_r, tgt_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [VW-1:0]          v_r, v_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [VW-1:0]          out_vert_r, out_vert_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_unr_r, out_unr_nxt;
  logic                   out_drop_r, out_drop_nxt;

  logic                   n_we;
  logic [AW-1:0]          n_waddr, n_raddr;
  logic [NE_W-1:0]        n_wdata, n_rdata;
  logic                   e_we;
  logic [EAW-1:0]         e_waddr, e_raddr;
  logic [EW-1:0]          e_wdata, e_rdata;
  logic                   s_we;
  logic [AW-1:0]          s_waddr, s_raddr;
  logic [VW-1:0]          s_wdata, s_rdata;

  logic [VW-1:0]          n_sat, n_m1, bv, ea, eb, par_v;
  logic [WEIGHT_BITS-1:0] ew;
  logic [31:0]            w32;
  logic [DW-1:0]          cand;
  logic                   out_free, accept, in_range, better;
  logic [ECW-1:0]         k_inc;

  sp_ram #(.WIDTH(NE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  sp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  sp_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_path_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign in_stall          = (state_r != ST_IDLE);
  assign accept            = in_valid && !in_stall;
  assign out_valid         = out_valid_r;
  assign out_path_vertex   = out_vert_r;
  assign out_last          = out_last_r;
  assign out_unreachable   = out_unr_r;
  assign out_edges_dropped = out_drop_r;
  assign out_free          = !out_valid_r || !out_stall;

  always_comb begin
    if (node_count_r == '0) begin
      n_sat = VW'(1);
    end else if (node_count_r > VW'(MAX_NODES)) begin
      n_sat = VW'(MAX_NODES);
    end else begin
      n_sat = node_count_r;
    end
  end

  assign n_m1  = n_sat - VW'(1);
  assign bv    = VW'(best_idx_r) + VW'(1);
  assign ea    = e_rdata[EW-1 -: VW];
  assign eb    = e_rdata[WEIGHT_BITS +: VW];
  assign ew    = e_rdata[WEIGHT_BITS-1:0];
  assign w32   = {{(32 - sp_pkg::WIN_W){1'b0}}, in_edge_weight};
  assign cand  = best_dist_r + DW'(w_r);
  assign k_inc = k_r + ECW'(1);
  assign better = n_rdata[RCH] && !n_rdata[VIS] &&
                  (!best_found_r || (n_rdata[DW-1:0] < best_dist_r));
  assign in_range = (in_edge_from != '0) && (in_edge_from <= VW'(MAX_NODES)) &&
                    (in_edge_to != '0) && (in_edge_to <= VW'(MAX_NODES));

  always_comb begin
    par_v = n_rdata[P_LO +: VW];
    if (par_v == '0 || par_v > VW'(MAX_NODES)) begin
      par_v = VW'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    edge_count_nxt = edge_count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    best_par_nxt   = best_par_r;
    k_nxt          = k_r;
    tgt_nxt        = tgt_r;
    w_nxt          = w_r;
    v_nxt          = v_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_vert_nxt   = out_vert_r;
    out_last_nxt   = out_last_r;
    out_unr_nxt    = out_unr_r;
    out_drop_nxt   = out_drop_r;

    n_we    = 1'b0;
    n_waddr = idx_r;
    n_wdata = '0;
    n_raddr = idx_r;
    e_we    = 1'b0;
    e_waddr = edge_count_r[EAW-1:0];
    e_wdata = {in_edge_from, in_edge_to, w32[WEIGHT_BITS-1:0]};
    e_raddr = k_r[EAW-1:0];
    s_we    = 1'b0;
    s_waddr = cnt_r[AW-1:0];
    s_wdata = v_r;
    s_raddr = cnt_r[AW-1:0] - AW'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            sp_pkg::OP_LOAD: begin
              if (in_range) begin
                if (edge_count_r >= ECW'(MAX_EDGES)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  e_we           = 1'b1;
                  edge_count_nxt = edge_count_r + ECW'(1);
                end
              end
            end
            sp_pkg::OP_CLEAR: begin
              edge_count_nxt = '0;
              ovf_nxt        = 1'b0;
            end
            sp_pkg::OP_RUN: begin
              idx_nxt   = '0;
              state_nxt = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        n_we    = 1'b1;
        n_wdata = '0;
        if (idx_r == '0) begin
          n_wdata[RCH] = 1'b1;
        end
        if (idx_r == n_m1[AW-1:0]) begin
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          state_nxt      = ST_SCAN_RD;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (better) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = idx_r;
          best_dist_nxt  = n_rdata[DW-1:0];
          best_par_nxt   = n_rdata[P_LO +: VW];
        end
        if (idx_r == n_m1[AW-1:0]) begin
          state_nxt = (better || best_found_r) ? ST_MARK : ST_P_CHK;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MARK: begin
        n_we    = 1'b1;
        n_waddr = best_idx_r;
        n_wdata = {1'b1, 1'b1, best_par_r, best_dist_r};
        k_nxt   = '0;
        if (edge_count_r == '0) begin
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          state_nxt      = ST_SCAN_RD;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_EV;
      end
      ST_E_EV: begin
        w_nxt = ew;
        if (ea <= n_sat && eb <= n_sat && ea != eb && (ea == bv || eb == bv)) begin
          tgt_nxt   = (ea == bv) ? eb : ea;
          n_raddr   = (ea == bv) ? AW'(eb - VW'(1)) : AW'(ea - VW'(1));
          state_nxt = ST_N_EV;
        end else if (k_inc == edge_count_r) begin
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          state_nxt      = ST_SCAN_RD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = ST_E_RD;
        end
      end
      ST_N_EV: begin
        // strict less-than keeps the first parent found on ties
        if (!n_rdata[RCH] || (cand < n_rdata[DW-1:0])) begin
          n_we    = 1'b1;
          n_waddr = AW'(tgt_r - VW'(1));
          n_wdata = {1'b1, n_rdata[VIS], bv, cand};
        end
        if (k_inc == edge_count_r) begin
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          state_nxt      = ST_SCAN_RD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = ST_E_RD;
        end
      end
      ST_P_CHK: begin
        n_raddr   = n_m1[AW-1:0];
        state_nxt = ST_P_CHKEV;
      end
      ST_P_CHKEV: begin
        n_raddr = n_m1[AW-1:0];
        if (!n_rdata[RCH]) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_vert_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_unr_nxt   = 1'b1;
            out_drop_nxt  = ovf_r;
            state_nxt     = ST_IDLE;
          end
        end else begin
          v_nxt     = n_sat;
          cnt_nxt   = '0;
          state_nxt = ST_P_PUSH;
        end
      end
      ST_P_PUSH: begin
        s_we    = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (v_r != VW'(1) && cnt_r < CW'(MAX_NODES - 1)) begin
          n_raddr   = AW'(v_r - VW'(1));
          state_nxt = ST_P_EV;
        end else begin
          s_wdata   = VW'(1);
          state_nxt = ST_O_RD;
        end
      end
      ST_P_EV: begin
        v_nxt     = par_v;
        state_nxt = ST_P_PUSH;
      end
      ST_O_RD: begin
        state_nxt = ST_O_EV;
      end
      ST_O_EV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt  = s_rdata;
          out_last_nxt  = (cnt_r == CW'(1));
          out_unr_nxt   = 1'b0;
          out_drop_nxt  = ovf_r;
          cnt_nxt       = cnt_r - CW'(1);
          state_nxt     = (cnt_r == CW'(1)) ? ST_IDLE : ST_O_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= VW'(64);
      edge_count_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    best_par_r   <= best_par_nxt;
    k_r          <= k_nxt;
    tgt_r        <= tgt_nxt;
    w_r          <= w_nxt;
    v_r          <= v_nxt;
    cnt_r        <= cnt_nxt;
    out_vert_r   <= out_vert_nxt;
    out_last_r   <= out_last_nxt;
    out_unr_r    <= out_unr_nxt;
    out_drop_r   <= out_drop_nxt;
  end

endmodule

### src/sp_checker.sv
`include "shortest_path_dijkstra_defines.svh"

module sp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_we,
  input logic [sp_pkg::VERT_W-1:0] cfg_wdata,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [sp_pkg::OP_W-1:0]   in_op,
  input logic [sp_pkg::VERT_W-1:0] in_edge_from,
  input logic [sp_pkg::VERT_W-1:0] in_edge_to,
  input logic [sp_pkg::WIN_W-1:0]  in_edge_weight,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [sp_pkg::VERT_W-1:0] out_path_vertex,
  input logic                      out_last,
  input logic                      out_unreachable,
  input logic                      out_edges_dropped
);

  `SP_ASSERT_IMP(a_out_hold, out_valid && out_stall, out_valid && $stable(out_path_vertex) && $stable(out_last), "stalled result changed")
  `SP_ASSERT(a_unr_form, !(out_valid && out_unreachable) || (out_last && out_path_vertex == 7'd0), "unreachable result malformed")
  `SP_ASSERT(a_vert_range, !(out_valid && !out_unreachable) || (out_path_vertex != 7'd0 && out_path_vertex <= 7'd64), "path vertex out of range")
  `SP_ASSERT_IMP(a_run_busy, in_valid && !in_stall && in_op == sp_pkg::OP_RUN, in_stall, "search did not hold off input")

endmodule

bind shortest_path_dijkstra sp_checker u_sp_checker (.*);

### test/shortest_path_dijkstra_tb.sv
`timescale 1ns / 100ps

module shortest_path_dijkstra_tb;

  localparam int VW          = sp_pkg::VERT_W;
  localparam int OW          = sp_pkg::OP_W;
  localparam int WW          = sp_pkg::WIN_W;
  localparam int NODES       = 64;
  localparam int EDGE_CAP    = 1024;
  localparam int STALL_LIMIT = 400000;
  localparam logic [OW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          last;
    logic          unreachable;
    logic          dropped;
  } hop_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [VW-1:0] cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  logic [OW-1:0] in_op;
  logic [VW-1:0] in_edge_from;
  logic [VW-1:0] in_edge_to;
  logic [WW-1:0] in_edge_weight;
  logic          out_valid;
  logic          out_stall;
  logic [VW-1:0] out_path_vertex;
  logic          out_last;
  logic          out_unreachable;
  logic          out_edges_dropped;

  // predictor copy of the graph
  logic [VW-1:0] g_from [EDGE_CAP];
  logic [VW-1:0] g_to [EDGE_CAP];
  logic [WW-1:0] g_weight [EDGE_CAP];
  int            g_count;
  bit            g_overflow;
  logic [VW-1:0] g_nodes;

  hop_t path_queue[$];
  int   mismatches;
  int   hops_seen;
  int   searches;
  int   idle_cycles;
  bit   sender_busy_mode;
  bit   hold_request;

  shortest_path_dijkstra u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_edge_from     (in_edge_from),
    .in_edge_to       (in_edge_to),
    .in_edge_weight   (in_edge_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_path_vertex  (out_path_vertex),
    .out_last         (out_last),
    .out_unreachable  (out_unreachable),
    .out_edges_dropped(out_edges_dropped)
  );

  always #2 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void solve_path();
    longint unsigned dist_v [1:NODES];
    longint unsigned cand;
    bit              reached [1:NODES];
    bit              settled [1:NODES];
    int              parent [1:NODES];
    int              route[$];
    int              n, best, k, v, a, b;
    hop_t            h;
    n = int'(g_nodes);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (v = 1; v <= NODES; v++) begin
      dist_v[v] = 0; reached[v] = 0; settled[v] = 0; parent[v] = 0;
    end
    reached[1] = 1;
    forever begin
      best = 0;
      for (v = 1; v <= n; v++)
        if (reached[v] && !settled[v] && (best == 0 || dist_v[v] < dist_v[best])) best = v;
      if (best == 0) break;
      settled[best] = 1;
      for (k = 0; k < g_count; k++) begin
        a = int'(g_from[k]);
        b = int'(g_to[k]);
        if (a > n || b > n) continue;
        if (a == best) begin
          cand = dist_v[best] + g_weight[k];
          if (!reached[b] || cand < dist_v[b]) begin
            reached[b] = 1; dist_v[b] = cand; parent[b] = best;
          end
        end
        if (b == best) begin
          cand = dist_v[best] + g_weight[k];
          if (!reached[a] || cand < dist_v[a]) begin
            reached[a] = 1; dist_v[a] = cand; parent[a] = best;
          end
        end
      end
    end
    if (!reached[n]) begin
      h = '{vertex: '0, last: 1'b1, unreachable: 1'b1, dropped: g_overflow};
      path_queue = {path_queue, h};
      return;
    end
    v = n;
    while (v != 1 && route.size() < NODES - 1) begin
      route = {route, v};
      v = parent[v];
      if (v < 1 || v > NODES) v = 1;
    end
    route = {route, 1};
    for (k = route.size() - 1; k >= 0; k--) begin
      h = '{vertex: VW'(route[k]), last: (k == 0), unreachable: 1'b0, dropped: g_overflow};
      path_queue = {path_queue, h};
    end
  endfunction

  function automatic void apply_item(input logic [OW-1:0] op, input logic [VW-1:0] a,
                                     input logic [VW-1:0] b, input logic [WW-1:0] w);
    case (op)
      sp_pkg::OP_LOAD: begin
        if (a >= 1 && a <= NODES && b >= 1 && b <= NODES) begin
          if (g_count >= EDGE_CAP) begin
            g_overflow = 1;
          end else begin
            g_from[g_count] = a; g_to[g_count] = b; g_weight[g_count] = w;
            g_count++;
          end
        end
      end
      sp_pkg::OP_CLEAR: begin
        g_count = 0;
        g_overflow = 0;
      end
      sp_pkg::OP_RUN: begin
        searches++;
        solve_path();
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [OW-1:0] op, input logic [VW-1:0] a,
                           input logic [VW-1:0] b, input logic [WW-1:0] w);
    int gap;
    gap = sender_busy_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_edge_from   <= a;
    in_edge_to     <= b;
    in_edge_weight <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    apply_item(op, a, b, w);
  endtask

  task automatic load_edge(input int a, input int b, input int w);
    send_item(sp_pkg::OP_LOAD, VW'(a), VW'(b), WW'(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (path_queue.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_nodes(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= VW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    g_nodes = VW'(value);
  endtask

  function automatic logic [WW-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return WW'($urandom_range(0, 3));
      1: return WW'($urandom_range(0, 20'hFFFFF));
      default: return WW'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic test_directed();
    set_nodes(4);
    send_item(sp_pkg::OP_CLEAR, '0, '0, '0);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);   // empty graph
    load_edge(1, 2, 5);
    load_edge(2, 4, 3);
    load_edge(1, 3, 1);
    load_edge(3, 4, 7);
    load_edge(1, 4, 8);                      // three equal-cost routes
    load_edge(3, 3, 0);                      // self loop
    load_edge(0, 2, 0);                      // bad endpoint, ignored
    load_edge(2, 127, 20'hFFFFF);            // bad endpoint, ignored
    load_edge(65, 1, 1);
    load_edge(2, 10, 0);                     // beyond node_count, skipped
    send_item(OP_UNUSED, 7'h7F, 7'h7F, 20'hFFFFF);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
    load_edge(4, 1, 0);                      // zero weight shortcut
    load_edge(2, 3, 20'hFFFFF);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
    set_nodes(1);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
    set_nodes(0);                            // saturates to one vertex
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
    set_nodes(127);                          // saturates to 64
    load_edge(1, 64, 20'hFFFFF);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
    set_nodes(64);
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
  endtask

  // loads back to back with no gaps, then a search over them
  task automatic test_capacity();
    set_nodes(3);
    send_item(sp_pkg::OP_CLEAR, '0, '0, '0);
    sender_busy_mode = 1;
    for (int i = 0; i < 6; i++)
      load_edge($urandom_range(1, 3), $urandom_range(1, 3), pick_weight());
    sender_busy_mode = 0;
    send_item(sp_pkg::OP_RUN, '0, '0, '0);
  endtask

  task automatic test_random();
    int sizes[6] = '{5, 8, 3, 6, 64, 10};
    int n, edges;
    for (int p = 0; p < 6; p++) begin
      n = sizes[p];
      set_nodes(n);
      sender_busy_mode = $urandom_range(0, 2) == 0;
      send_item(sp_pkg::OP_CLEAR, '0, '0, '0);
      if (n == 64) begin
        // chain with random shortcuts so the far target is reachable
        for (int v = 1; v < 64; v++) begin
          load_edge(v, v + 1, pick_weight());
          if ($urandom_range(0, 7) == 0)
            load_edge($urandom_range(1, 64), $urandom_range(1, 64), pick_weight());
        end
        send_item(sp_pkg::OP_RUN, '0, '0, '0);
      end else begin
        edges = $urandom_range(n, 2 * n + 4);
        for (int i = 0; i < edges; i++) begin
          case ($urandom_range(0, 11))
            0: send_item(OP_UNUSED, VW'($urandom), VW'($urandom), WW'($urandom));
            1: load_edge($urandom_range(0, 127), $urandom_range(0, 127), int'($urandom));
            2: send_item(sp_pkg::OP_RUN, '0, '0, '0);
            default: load_edge($urandom_range(1, n), $urandom_range(1, n), pick_weight());
          endcase
        end
        send_item(sp_pkg::OP_RUN, '0, '0, '0);
        set_nodes($urandom_range(1, 127));
        send_item(sp_pkg::OP_RUN, '0, '0, '0);
      end
    end
    sender_busy_mode = 0;
  endtask

  task automatic test_backpressure();
    set_nodes(6);
    send_item(sp_pkg::OP_CLEAR, '0, '0, '0);
    for (int v = 1; v < 6; v++) load_edge(v, v + 1, $urandom_range(0, 9));
    hold_request = 1;
    sender_busy_mode = 1;
    for (int i = 0; i < 4; i++) begin
      send_item(sp_pkg::OP_RUN, '0, '0, '0);
      load_edge(1, 6, $urandom_range(0, 30));
    end
    sender_busy_mode = 0;
  endtask

  // result side: random stall per transaction, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    hop_t want;
    if (rst_n && out_valid && !out_stall) begin
      hops_seen++;
      if (path_queue.size() == 0) begin
        report("unexpected transaction, vertex", int'(out_path_vertex), 0);
      end else begin
        want = path_queue.pop_front();
        if (out_unreachable !== want.unreachable)
          report("unreachable", int'(out_unreachable), int'(want.unreachable));
        if (!want.unreachable && out_path_vertex !== want.vertex)
          report("path_vertex", int'(out_path_vertex), int'(want.vertex));
        if (out_last !== want.last) report("last", int'(out_last), int'(want.last));
        if (out_edges_dropped !== want.dropped)
          report("edges_dropped", int'(out_edges_dropped), int'(want.dropped));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d transactions outstanding", path_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = sp_pkg::OP_LOAD;
    in_edge_from = '0;
    in_edge_to = '0;
    in_edge_weight = '0;
    mismatches = 0;
    hops_seen = 0;
    searches = 0;
    idle_cycles = 0;
    sender_busy_mode = 0;
    hold_request = 0;
    g_count = 0;
    g_overflow = 0;
    g_nodes = 64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_random();
    test_backpressure();

    drain();
    repeat (50) @(posedge clk);
    $display("%0d searches, %0d path transactions checked", searches, hops_seen);
    $display("covered ties, saturation, bad endpoints, load bursts and long output stall");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
